// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the heap RTL.
// Every macro samples on the rising edge of clk and is disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in every cycle outside reset.
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants of the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int POS2_W     = CNT_W + 1;
  localparam int KEY_W      = 32;

  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [POS2_W-1:0]        pos2_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [KEY_W-1:0]  key_t;

  localparam cnt_t CNT_FULL = cnt_t'(HEAP_DEPTH);
  localparam cnt_t CNT_ONE  = cnt_t'(1);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DEL_LAST,
    S_DEL_WAIT,
    S_SU_RD,
    S_SU_CMP,
    S_SD_RDL,
    S_SD_RDR,
    S_SD_CMP,
    S_WR_CUR,
    S_DONE
  } state_t;

endpackage

// ===== hdl/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/min_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap of signed 32-bit keys with insert and delete-by-value.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (cmd_valid/cmd_ready, command, value): command 0 inserts
//   value, command 1 deletes the first stored entry equal to value.
//   Response channel (rsp_valid/rsp_ready): one response per request with the
//   minimum after the operation (0 when empty), heap_empty, entry_count and
//   status (ok, delete value not found, insert refused because full).
//   One request is processed at a time; cmd_ready is high only when idle.
//   Work per request is serialized by the single read port of the key RAM:
//     insert : a sift-up that climbs the tree one level at a time
//     delete : a linear scan over the n entries, then a sift-down or a
//              sift-up through the tree levels
//   The response sits in an output register; a new request is taken while
//   it waits. If the receiver stalls, the next request finishes and then
//   waits until the output register is free.
//   Reset (synchronous, rst) empties the heap at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module min_heap_priority_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic                         command,
  input  logic signed [31:0]           value,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic signed [31:0]           min_value,
  output logic                         heap_empty,
  output logic [mhpq_pkg::CNT_W-1:0]   entry_count,
  output logic [1:0]                   status
);

  mhpq_pkg::state_t  state, state_next;
  mhpq_pkg::cnt_t    count;
  mhpq_pkg::cnt_t    pos;
  mhpq_pkg::cnt_t    issue_pos;
  mhpq_pkg::cnt_t    chk_pos;
  logic              chk_valid;
  mhpq_pkg::key_t    key_in;
  mhpq_pkg::key_t    cur;
  mhpq_pkg::key_t    left_val;
  mhpq_pkg::key_t    root;
  logic              right_ok;
  logic              first_up;
  mhpq_pkg::status_t stat;
  mhpq_pkg::status_t rsp_status;

  // RAM port signals
  logic              rd_en, wr_en;
  mhpq_pkg::cnt_t    rd_pos, wr_pos;
  mhpq_pkg::cnt_t    rd_off, wr_off;
  mhpq_pkg::key_t    wr_data;
  mhpq_pkg::key_t    rd_data;

  // Tree navigation
  mhpq_pkg::cnt_t    parent_pos;
  mhpq_pkg::pos2_t   left_pos, right_pos, count2;
  logic              up_less;
  logic              sel_left, sel_right, sel_any;
  mhpq_pkg::key_t    cmp_base;
  mhpq_pkg::key_t    child_val;
  mhpq_pkg::cnt_t    child_pos;
  logic              scan_hit, scan_miss;
  logic              accept;
  logic              rsp_load;

  assign accept     = cmd_valid && cmd_ready;
  assign parent_pos = {1'b0, pos[mhpq_pkg::CNT_W-1:1]};
  assign left_pos   = {pos, 1'b0};
  assign right_pos  = {pos, 1'b1};
  assign count2     = {1'b0, count};

  assign up_less    = cur < rd_data;
  assign sel_left   = left_val < cur;
  assign cmp_base   = sel_left ? left_val : cur;
  assign sel_right  = right_ok && (rd_data < cmp_base);
  assign sel_any    = sel_left || sel_right;
  assign child_val  = sel_right ? rd_data : left_val;
  assign child_pos  = sel_right ? right_pos[mhpq_pkg::CNT_W-1:0]
                                : left_pos[mhpq_pkg::CNT_W-1:0];

  // scan pipeline: data for chk_pos arrives in the cycle after its read
  assign scan_hit   = chk_valid && (rd_data == key_in);
  assign scan_miss  = chk_valid && !scan_hit && (chk_pos == count);

  assign rsp_load   = (state == mhpq_pkg::S_DONE) && (!rsp_valid || rsp_ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          if (mhpq_pkg::cmd_t'(command) == mhpq_pkg::CMD_INSERT) begin
            if (count == mhpq_pkg::CNT_FULL) state_next = mhpq_pkg::S_DONE;
            else if (count == '0)            state_next = mhpq_pkg::S_WR_CUR;
            else                             state_next = mhpq_pkg::S_SU_RD;
          end else begin
            if (count == '0) state_next = mhpq_pkg::S_DONE;
            else             state_next = mhpq_pkg::S_SCAN;
          end
        end
      end
      mhpq_pkg::S_SCAN: begin
        if (scan_hit)       state_next = mhpq_pkg::S_DEL_LAST;
        else if (scan_miss) state_next = mhpq_pkg::S_DONE;
      end
      mhpq_pkg::S_DEL_LAST: state_next = mhpq_pkg::S_DEL_WAIT;
      mhpq_pkg::S_DEL_WAIT: begin
        // removing the last slot needs no sifting
        if (pos == count)                 state_next = mhpq_pkg::S_DONE;
        else if (pos == mhpq_pkg::CNT_ONE) state_next = mhpq_pkg::S_SD_RDL;
        else                              state_next = mhpq_pkg::S_SU_RD;
      end
      mhpq_pkg::S_SU_RD: state_next = mhpq_pkg::S_SU_CMP;
      mhpq_pkg::S_SU_CMP: begin
        if (up_less) begin
          if (parent_pos == mhpq_pkg::CNT_ONE) state_next = mhpq_pkg::S_WR_CUR;
          else                                 state_next = mhpq_pkg::S_SU_RD;
        end else if (first_up) begin
          state_next = mhpq_pkg::S_SD_RDL;
        end else begin
          state_next = mhpq_pkg::S_WR_CUR;
        end
      end
      mhpq_pkg::S_SD_RDL: begin
        if (left_pos > count2) state_next = mhpq_pkg::S_WR_CUR;
        else                   state_next = mhpq_pkg::S_SD_RDR;
      end
      mhpq_pkg::S_SD_RDR: state_next = mhpq_pkg::S_SD_CMP;
      mhpq_pkg::S_SD_CMP: begin
        if (sel_any) state_next = mhpq_pkg::S_SD_RDL;
        else         state_next = mhpq_pkg::S_WR_CUR;
      end
      mhpq_pkg::S_WR_CUR: state_next = mhpq_pkg::S_DONE;
      mhpq_pkg::S_DONE: begin
        if (rsp_load) state_next = mhpq_pkg::S_IDLE;
      end
      default: state_next = mhpq_pkg::S_IDLE;
    endcase
  end

  // RAM control and handshake outputs
  always_comb begin
    cmd_ready = (state == mhpq_pkg::S_IDLE);
    rd_en     = 1'b0;
    rd_pos    = pos;
    wr_en     = 1'b0;
    wr_pos    = pos;
    wr_data   = cur;
    unique case (state)
      mhpq_pkg::S_SCAN: begin
        rd_en  = issue_pos <= count;
        rd_pos = issue_pos;
      end
      mhpq_pkg::S_DEL_LAST: begin
        rd_en  = 1'b1;
        rd_pos = count;
      end
      mhpq_pkg::S_SU_RD: begin
        rd_en  = 1'b1;
        rd_pos = parent_pos;
      end
      mhpq_pkg::S_SU_CMP: begin
        // hole moves up: parent drops into the current slot
        wr_en   = up_less;
        wr_data = rd_data;
      end
      mhpq_pkg::S_SD_RDL: begin
        rd_en  = left_pos <= count2;
        rd_pos = left_pos[mhpq_pkg::CNT_W-1:0];
      end
      mhpq_pkg::S_SD_RDR: begin
        rd_en  = right_pos <= count2;
        rd_pos = right_pos[mhpq_pkg::CNT_W-1:0];
      end
      mhpq_pkg::S_SD_CMP: begin
        wr_en   = sel_any;
        wr_data = child_val;
      end
      mhpq_pkg::S_WR_CUR: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // positions are 1-based
  assign rd_off = rd_pos - mhpq_pkg::CNT_ONE;
  assign wr_off = wr_pos - mhpq_pkg::CNT_ONE;

  mhpq_ram #(
    .WIDTH (mhpq_pkg::KEY_W),
    .DEPTH (mhpq_pkg::HEAP_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_off[mhpq_pkg::ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_off[mhpq_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mhpq_pkg::S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      // root copy tracks every write to slot 1
      if (wr_en && wr_pos == mhpq_pkg::CNT_ONE) begin
        root <= wr_data;
      end

      unique case (state)
        mhpq_pkg::S_IDLE: begin
          if (accept) begin
            key_in    <= value;
            cur       <= value;
            first_up  <= 1'b0;
            issue_pos <= mhpq_pkg::CNT_ONE;
            chk_valid <= 1'b0;
            if (mhpq_pkg::cmd_t'(command) == mhpq_pkg::CMD_INSERT) begin
              if (count == mhpq_pkg::CNT_FULL) begin
                stat <= mhpq_pkg::ST_FULL;
              end else begin
                stat  <= mhpq_pkg::ST_OK;
                count <= count + mhpq_pkg::CNT_ONE;
                pos   <= count + mhpq_pkg::CNT_ONE;
              end
            end else if (count == '0) begin
              stat <= mhpq_pkg::ST_NOT_FOUND;
            end else begin
              stat <= mhpq_pkg::ST_OK;
            end
          end
        end
        mhpq_pkg::S_SCAN: begin
          chk_valid <= rd_en && !scan_hit && !scan_miss;
          chk_pos   <= issue_pos;
          if (rd_en) begin
            issue_pos <= issue_pos + mhpq_pkg::CNT_ONE;
          end
          if (scan_hit) begin
            pos <= chk_pos;
          end else if (scan_miss) begin
            stat <= mhpq_pkg::ST_NOT_FOUND;
          end
        end
        mhpq_pkg::S_DEL_WAIT: begin
          cur      <= rd_data;
          count    <= count - mhpq_pkg::CNT_ONE;
          first_up <= 1'b1;
        end
        mhpq_pkg::S_SU_CMP: begin
          if (up_less) begin
            pos      <= parent_pos;
            first_up <= 1'b0;
          end
        end
        mhpq_pkg::S_SD_RDR: begin
          left_val <= rd_data;
          right_ok <= right_pos <= count2;
        end
        mhpq_pkg::S_SD_CMP: begin
          if (sel_any) begin
            pos <= child_pos;
          end
        end
        mhpq_pkg::S_DONE: begin
          if (rsp_load) begin
            min_value   <= (count != '0) ? root : '0;
            heap_empty  <= (count == '0);
            entry_count <= count;
            rsp_status  <= stat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status = rsp_status;

  `MHPQ_ASSERT(a_count_max, count <= mhpq_pkg::CNT_FULL, "entry count above heap depth")
  `MHPQ_ASSERT(a_wr_in_heap, !wr_en || (wr_pos != '0 && wr_pos <= count), "write outside heap")
  `MHPQ_ASSERT(a_rd_in_heap, !rd_en || (rd_pos != '0 && rd_pos <= count), "read outside heap")
  `MHPQ_ASSERT_NEXT(a_count_hold, state != mhpq_pkg::S_IDLE && state != mhpq_pkg::S_DEL_WAIT, $stable(count), "count changed mid-operation")
  `MHPQ_ASSERT(a_rsp_empty, !rsp_valid || (heap_empty == (entry_count == '0)), "empty flag disagrees with count")

endmodule
